/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed in scan code checker");

// Same, on the default clock and reset names clk and arst_n.
`define ASSERT_STD(label, prop) \
	`ASSERT_CLKD(label, clk, arst_n, prop)

`endif

/* hdl/s2a_pkg.sv */
// ---------------------------------------------------------------------------
// s2a_pkg
// Types, codes and key tables for the scan code to ASCII queue.
// ---------------------------------------------------------------------------
package s2a_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int LEVEL_W = 9;

	// Request commands.
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	// Scan codes with special handling (set 1, make codes).
	localparam logic [6:0] KEY_SHIFT_L = 7'h2A;
	localparam logic [6:0] KEY_SHIFT_R = 7'h36;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam logic [6:0] KEY_RETURN  = 7'h1C;
	localparam logic [6:0] KEY_BKSP    = 7'h0E;
	localparam logic [6:0] KEY_TAB     = 7'h0F;
	localparam logic [6:0] KEY_ESC     = 7'h01;
	localparam logic [7:0] SCAN_PREFIX = 8'hE0;

	// Control characters produced by the special keys.
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;

	// Outcome of decoding one scan byte.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              shift_nxt;
		logic              caps_nxt;
	} key_result_t;

	// Unshifted key map; zero means the key makes no character.
	function automatic logic [CHAR_W-1:0] map_plain(input logic [6:0] key);
		logic [CHAR_W-1:0] c;
		case (key)
			7'h02: c = 8'h31; 7'h03: c = 8'h32; 7'h04: c = 8'h33; 7'h05: c = 8'h34;
			7'h06: c = 8'h35; 7'h07: c = 8'h36; 7'h08: c = 8'h37; 7'h09: c = 8'h38;
			7'h0A: c = 8'h39; 7'h0B: c = 8'h30; 7'h0C: c = 8'h2D; 7'h0D: c = 8'h3D;
			7'h10: c = 8'h71; 7'h11: c = 8'h77; 7'h12: c = 8'h65; 7'h13: c = 8'h72;
			7'h14: c = 8'h74; 7'h15: c = 8'h79; 7'h16: c = 8'h75; 7'h17: c = 8'h69;
			7'h18: c = 8'h6F; 7'h19: c = 8'h70; 7'h1A: c = 8'h5B; 7'h1B: c = 8'h5D;
			7'h1E: c = 8'h61; 7'h1F: c = 8'h73; 7'h20: c = 8'h64; 7'h21: c = 8'h66;
			7'h22: c = 8'h67; 7'h23: c = 8'h68; 7'h24: c = 8'h6A; 7'h25: c = 8'h6B;
			7'h26: c = 8'h6C; 7'h27: c = 8'h3B; 7'h28: c = 8'h27; 7'h29: c = 8'h60;
			7'h2B: c = 8'h5C; 7'h2C: c = 8'h7A; 7'h2D: c = 8'h78; 7'h2E: c = 8'h63;
			7'h2F: c = 8'h76; 7'h30: c = 8'h62; 7'h31: c = 8'h6E; 7'h32: c = 8'h6D;
			7'h33: c = 8'h2C; 7'h34: c = 8'h2E; 7'h35: c = 8'h2F; 7'h37: c = 8'h2A;
			7'h39: c = 8'h20; 7'h4A: c = 8'h2D; 7'h4E: c = 8'h2B;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Shifted key map.
	function automatic logic [CHAR_W-1:0] map_upper(input logic [6:0] key);
		logic [CHAR_W-1:0] c;
		case (key)
			7'h02: c = 8'h21; 7'h03: c = 8'h40; 7'h04: c = 8'h23; 7'h05: c = 8'h24;
			7'h06: c = 8'h25; 7'h07: c = 8'h5E; 7'h08: c = 8'h26; 7'h09: c = 8'h2A;
			7'h0A: c = 8'h28; 7'h0B: c = 8'h29; 7'h0C: c = 8'h5F; 7'h0D: c = 8'h2B;
			7'h10: c = 8'h51; 7'h11: c = 8'h57; 7'h12: c = 8'h45; 7'h13: c = 8'h52;
			7'h14: c = 8'h54; 7'h15: c = 8'h59; 7'h16: c = 8'h55; 7'h17: c = 8'h49;
			7'h18: c = 8'h4F; 7'h19: c = 8'h50; 7'h1A: c = 8'h7B; 7'h1B: c = 8'h7D;
			7'h1E: c = 8'h41; 7'h1F: c = 8'h53; 7'h20: c = 8'h44; 7'h21: c = 8'h46;
			7'h22: c = 8'h47; 7'h23: c = 8'h48; 7'h24: c = 8'h4A; 7'h25: c = 8'h4B;
			7'h26: c = 8'h4C; 7'h27: c = 8'h3A; 7'h28: c = 8'h22; 7'h29: c = 8'h7E;
			7'h2B: c = 8'h7C; 7'h2C: c = 8'h5A; 7'h2D: c = 8'h58; 7'h2E: c = 8'h43;
			7'h2F: c = 8'h56; 7'h30: c = 8'h42; 7'h31: c = 8'h4E; 7'h32: c = 8'h4D;
			7'h33: c = 8'h3C; 7'h34: c = 8'h3E; 7'h35: c = 8'h3F; 7'h37: c = 8'h2A;
			7'h39: c = 8'h20; 7'h4A: c = 8'h2D; 7'h4E: c = 8'h2B;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* hdl/s2a_if.sv */
// ---------------------------------------------------------------------------
// s2a_if
// Valid/ready channels for scan code requests and character responses.
// ---------------------------------------------------------------------------
interface s2a_req_if;
	logic                         valid;
	logic                         ready;
	logic [s2a_pkg::CMD_W-1:0]    command;
	logic [7:0]                   scan_byte;

	modport source (output valid, output command, output scan_byte, input ready);
	modport sink   (input valid, input command, input scan_byte, output ready);
endinterface

interface s2a_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [s2a_pkg::CHAR_W-1:0]   out_char;
	logic                         char_valid;
	logic [s2a_pkg::LEVEL_W-1:0]  queue_level;
	logic                         dropped;

	modport source (output valid, output out_char, output char_valid,
		output queue_level, output dropped, input ready);
	modport sink   (input valid, input out_char, input char_valid,
		input queue_level, input dropped, output ready);
endinterface

/* hdl/s2a_decode.sv */
// ---------------------------------------------------------------------------
// s2a_decode
// Translates one set-1 scan byte and computes the next modifier state.
// ---------------------------------------------------------------------------
module s2a_decode (
	input  logic [7:0]           scan_byte,
	input  logic                 shift_held,
	input  logic                 caps_active,
	output s2a_pkg::key_result_t result
);

	logic [6:0]                  key;
	logic [s2a_pkg::CHAR_W-1:0]  mapped;
	logic                        is_shift;

	assign key      = scan_byte[6:0];
	assign is_shift = (key == s2a_pkg::KEY_SHIFT_L) || (key == s2a_pkg::KEY_SHIFT_R);

	always_comb begin
		mapped = shift_held ? s2a_pkg::map_upper(key) : s2a_pkg::map_plain(key);
		// Caps lock flips the case of letters only.
		if (caps_active && !shift_held && mapped >= 8'h61 && mapped <= 8'h7A) begin
			mapped = mapped - 8'h20;
		end else if (caps_active && shift_held && mapped >= 8'h41 && mapped <= 8'h5A) begin
			mapped = mapped + 8'h20;
		end

		result.ch        = '0;
		result.shift_nxt = shift_held;
		result.caps_nxt  = caps_active;

		if (scan_byte == s2a_pkg::SCAN_PREFIX) begin
			// Extended prefix is ignored entirely.
		end else if (scan_byte[7]) begin
			if (is_shift) begin
				result.shift_nxt = 1'b0;
			end
		end else if (is_shift) begin
			result.shift_nxt = 1'b1;
		end else begin
			case (key)
				s2a_pkg::KEY_CAPS:   result.caps_nxt = !caps_active;
				s2a_pkg::KEY_RETURN: result.ch = s2a_pkg::CH_LF;
				s2a_pkg::KEY_BKSP:   result.ch = s2a_pkg::CH_BS;
				s2a_pkg::KEY_TAB:    result.ch = s2a_pkg::CH_TAB;
				s2a_pkg::KEY_ESC:    result.ch = s2a_pkg::CH_ESC;
				default:             result.ch = mapped;
			endcase
		end
	end

endmodule

/* hdl/scancode_to_ascii_fifo.sv */
// ---------------------------------------------------------------------------
// scancode_to_ascii_fifo
// PS/2 set-1 scan code translator feeding a character queue.
// ---------------------------------------------------------------------------
//
//  Channel | Modport | Payload                                     | Handshake
//  --------+---------+---------------------------------------------+----------
//  req     | sink    | command, scan_byte                          | valid/ready
//  rsp     | source  | out_char, char_valid, queue_level, dropped  | valid/ready
//
// Decode, modifier update and queue access sit between the request
// handshake and the response register, so a new request is taken in every
// cycle while the response side keeps up.
// The response for a request is visible in the cycle after it is accepted.
// A request is accepted while the response register is empty or being
// drained in the same cycle; a stalled response stalls only new requests.
// Reset clears the pointers, the fill count and the modifier flags at once;
// the character memory is not cleared, as only written entries are read.
//
module scancode_to_ascii_fifo #(
	parameter int QUEUE_DEPTH = s2a_pkg::QUEUE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	s2a_req_if.sink     req,
	s2a_rsp_if.source   rsp
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Queue and modifier state.
	logic [PTR_W-1:0]             rd_ptr_q, wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_nxt, wr_ptr_nxt;
	logic [CNT_W-1:0]             count_q, count_nxt;
	logic                         shift_q, caps_q;
	logic                         shift_nxt, caps_nxt;

	// Character memory, one write and one registered read port.
	logic [s2a_pkg::CHAR_W-1:0]   char_store_q [QUEUE_DEPTH];
	logic [s2a_pkg::CHAR_W-1:0]   rd_data_q;

	// Response register.
	logic                         rsp_valid_q;
	logic                         char_valid_q;
	logic                         dropped_q;
	logic [s2a_pkg::LEVEL_W-1:0]  level_q;

	logic                         accept;
	logic                         wr_en, rd_en, lost;
	logic                         full;
	s2a_pkg::key_result_t         key_res;

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// The response slot frees up whenever the consumer takes its content.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));

	s2a_decode u_decode (
		.scan_byte   (req.scan_byte),
		.shift_held  (shift_q),
		.caps_active (caps_q),
		.result      (key_res)
	);

	// Next-state logic for one request. Enables are qualified by accept
	// where they reach registers and the memory.
	always_comb begin
		rd_ptr_nxt = rd_ptr_q;
		wr_ptr_nxt = wr_ptr_q;
		count_nxt  = count_q;
		shift_nxt  = shift_q;
		caps_nxt   = caps_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		lost       = 1'b0;
		unique case (req.command)
			s2a_pkg::CMD_PUSH: begin
				shift_nxt = key_res.shift_nxt;
				caps_nxt  = key_res.caps_nxt;
				if (key_res.ch != '0) begin
					if (full) begin
						// No room: the character is lost and flagged.
						lost = 1'b1;
					end else begin
						wr_en      = 1'b1;
						wr_ptr_nxt = ptr_adv(wr_ptr_q);
						count_nxt  = count_q + CNT_W'(1);
					end
				end
			end
			s2a_pkg::CMD_READ: begin
				// A read from an empty queue changes nothing.
				if (count_q != '0) begin
					rd_en      = 1'b1;
					rd_ptr_nxt = ptr_adv(rd_ptr_q);
					count_nxt  = count_q - CNT_W'(1);
				end
			end
			s2a_pkg::CMD_FLUSH: begin
				rd_ptr_nxt = '0;
				wr_ptr_nxt = '0;
				count_nxt  = '0;
			end
			default: begin
				// The unused command only reports the level.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
		end else if (accept) begin
			rd_ptr_q <= rd_ptr_nxt;
			wr_ptr_q <= wr_ptr_nxt;
			count_q  <= count_nxt;
			shift_q  <= shift_nxt;
			caps_q   <= caps_nxt;
		end
	end

	// A pop never targets the entry pushed in the same cycle, since each
	// request either pushes or pops, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			char_store_q[wr_ptr_q] <= key_res.ch;
		end
	end

	// The read data register is loaded only together with the response
	// register, so it stays aligned with the response it belongs to.
	always_ff @(posedge clk) begin
		if (accept && rd_en) begin
			rd_data_q <= char_store_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_valid_q <= rd_en;
			dropped_q    <= lost;
			level_q      <= s2a_pkg::LEVEL_W'(count_nxt);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_char    = char_valid_q ? rd_data_q : '0;
	assign rsp.char_valid  = char_valid_q;
	assign rsp.queue_level = level_q;
	assign rsp.dropped     = dropped_q;

endmodule

/* hdl/s2a_checker.sv */
// ---------------------------------------------------------------------------
// s2a_checker
// Port-level assertions for the scan code queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module s2a_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [s2a_pkg::CMD_W-1:0]   command,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [s2a_pkg::CHAR_W-1:0]  out_char,
	input logic                        char_valid,
	input logic [s2a_pkg::LEVEL_W-1:0] queue_level,
	input logic                        dropped
);

	logic req_fire;

	assign req_fire = req_valid && req_ready;

	// A stalled response keeps its content.
	`ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_char) && $stable(char_valid) && $stable(queue_level) && $stable(dropped))

	// A flush leaves an empty queue and reports nothing else.
	`ASSERT_STD(a_flush_empty, req_fire && command == s2a_pkg::CMD_FLUSH |=> rsp_valid && queue_level == '0 && !char_valid && !dropped)

	// Only a read request can return a character.
	`ASSERT_STD(a_char_from_read, req_fire && command != s2a_pkg::CMD_READ |=> !char_valid && out_char == '0)

	// Zero is never queued, so a returned character is never zero.
	`ASSERT_STD(a_char_nonzero, rsp_valid && char_valid |-> out_char != '0 && !dropped)

endmodule

bind scancode_to_ascii_fifo s2a_checker u_s2a_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.command     (req.command),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.out_char    (rsp.out_char),
	.char_valid  (rsp.char_valid),
	.queue_level (rsp.queue_level),
	.dropped     (rsp.dropped)
);

/* dv/tb_scancode_to_ascii_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo
// Self-checking bench for the scan code translator and its character queue.
// The bench drives requests on the request channel and keeps its own copy of
// the keyboard state and the character queue. Every response that is taken
// from the block is compared, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo;

	localparam int QUEUE_DEPTH = s2a_pkg::QUEUE_DEPTH_DEF;
	localparam time CLK_PERIOD = 12ns;

	// Command 3 has no meaning to the block; it only reports the level.
	localparam logic [s2a_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

	// Top bit of a scan byte marks a key release.
	localparam logic RELEASE = 1'b1;
	localparam logic PRESS   = 1'b0;

	// One response as the block should present it.
	typedef struct packed {
		logic [s2a_pkg::CHAR_W-1:0]  out_char;
		logic                        char_valid;
		logic [s2a_pkg::LEVEL_W-1:0] queue_level;
		logic                        dropped;
	} reply_t;

	// One row of the directed stimulus. Where typed is set, the reply in the
	// row is the expected response; otherwise the predictor supplies it.
	typedef struct packed {
		logic [s2a_pkg::CMD_W-1:0] cmd;
		logic [7:0]                scan;
		logic                      typed;
		reply_t                    reply;
	} row_t;

	logic clk;
	logic arst_n;

	s2a_req_if req_if();
	s2a_rsp_if rsp_if();

	scancode_to_ascii_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Predicted keyboard state and queue contents.
	logic       shift_on;
	logic       caps_on;
	logic [7:0] char_fifo [$];

	// Responses that are owed by the block, oldest first.
	reply_t pending_replies [$];

	// Percentages of cycles in which each side holds off.
	int send_idle_pct;
	int recv_idle_pct;
	int error_count;

	// The directed walk: every special key, both modifiers, caps lock with
	// and without shift, the prefix byte, releases, unmapped keys at both
	// ends of the byte range, the spare command, reads, a flush and reads of
	// an empty queue.
	row_t directed_rows [25] = '{
		'{s2a_pkg::CMD_READ,  8'h00,                 1'b1, '{8'h00, 1'b0, 9'd0, 1'b0}},
		'{s2a_pkg::CMD_PUSH,  {PRESS, 7'h1E},        1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  s2a_pkg::SCAN_PREFIX,  1'b1, '{8'h00, 1'b0, 9'd1, 1'b0}},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_SHIFT_L},   1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, 7'h1E},        1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {RELEASE, s2a_pkg::KEY_SHIFT_L}, 1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_CAPS},      1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, 7'h10},        1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_SHIFT_R},   1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, 7'h10},        1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, 7'h02},        1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {RELEASE, s2a_pkg::KEY_SHIFT_R}, 1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_CAPS},      1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_RETURN},    1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_BKSP},      1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_TAB},       1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  {PRESS, s2a_pkg::KEY_ESC},       1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  8'h00,                 1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  8'hFF,                 1'b0, '0},
		'{s2a_pkg::CMD_PUSH,  8'h7F,                 1'b0, '0},
		'{CMD_SPARE,          8'hFF,                 1'b0, '0},
		'{s2a_pkg::CMD_READ,  8'h00,                 1'b0, '0},
		'{s2a_pkg::CMD_READ,  8'h00,                 1'b0, '0},
		'{s2a_pkg::CMD_FLUSH, 8'h00,                 1'b1, '{8'h00, 1'b0, 9'd0, 1'b0}},
		'{s2a_pkg::CMD_READ,  8'h00,                 1'b1, '{8'h00, 1'b0, 9'd0, 1'b0}}
	};

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake. A correct run needs
	// well under a tenth of this.
	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	// Character a key makes from its make code, with or without shift. Keys
	// are grouped by keyboard row, so a row is a string indexed by offset.
	function automatic logic [7:0] key_char(input logic [6:0] key, input logic up);
		string digit_row;
		string top_row;
		string home_row;
		string bottom_row;
		int    k;
		logic [7:0] c;
		digit_row  = up ? "!@#$%^&*()_+" : "1234567890-=";
		top_row    = up ? "QWERTYUIOP{}" : "qwertyuiop[]";
		home_row   = up ? "ASDFGHJKL:\"" : "asdfghjkl;'";
		bottom_row = up ? "|ZXCVBNM<>?"  : "\\zxcvbnm,./";
		k = int'(key);
		c = 8'h00;
		if (k >= 'h02 && k <= 'h0D)
			c = digit_row[k - 'h02];
		else if (k >= 'h10 && k <= 'h1B)
			c = top_row[k - 'h10];
		else if (k >= 'h1E && k <= 'h28)
			c = home_row[k - 'h1E];
		else if (k == 'h29)
			c = up ? "~" : 8'h60;  // back quote
		else if (k >= 'h2B && k <= 'h35)
			c = bottom_row[k - 'h2B];
		else if (k == 'h37)
			c = "*";  // keypad star, same either way
		else if (k == 'h39)
			c = " ";
		else if (k == 'h4A)
			c = "-";
		else if (k == 'h4E)
			c = "+";
		return c;
	endfunction

	// Applies one accepted request to the predicted state and returns the
	// response the block owes for it.
	function automatic reply_t apply_request(input logic [s2a_pkg::CMD_W-1:0] cmd,
		input logic [7:0] scan);
		reply_t     r;
		logic [6:0] key;
		logic [7:0] ch;
		r   = '0;
		key = scan[6:0];
		ch  = 8'h00;
		case (cmd)
			s2a_pkg::CMD_PUSH: begin
				if (scan == s2a_pkg::SCAN_PREFIX) begin
					ch = 8'h00;  // extended prefix: nothing at all
				end else if (scan[7]) begin
					// Only a shift release matters; other releases are ignored.
					if (key == s2a_pkg::KEY_SHIFT_L || key == s2a_pkg::KEY_SHIFT_R)
						shift_on = 1'b0;
				end else if (key == s2a_pkg::KEY_SHIFT_L || key == s2a_pkg::KEY_SHIFT_R) begin
					shift_on = 1'b1;
				end else if (key == s2a_pkg::KEY_CAPS) begin
					caps_on = ~caps_on;
				end else if (key == s2a_pkg::KEY_RETURN) begin
					ch = s2a_pkg::CH_LF;
				end else if (key == s2a_pkg::KEY_BKSP) begin
					ch = s2a_pkg::CH_BS;
				end else if (key == s2a_pkg::KEY_TAB) begin
					ch = s2a_pkg::CH_TAB;
				end else if (key == s2a_pkg::KEY_ESC) begin
					ch = s2a_pkg::CH_ESC;
				end else begin
					ch = key_char(key, shift_on);
					// Caps lock inverts the case of letters only; bit 5 is the
					// case bit in ASCII.
					if (caps_on && !shift_on && ch >= "a" && ch <= "z")
						ch = ch ^ 8'h20;
					else if (caps_on && shift_on && ch >= "A" && ch <= "Z")
						ch = ch ^ 8'h20;
				end
				if (ch != 8'h00) begin
					if (char_fifo.size() >= QUEUE_DEPTH)
						r.dropped = 1'b1;
					else
						char_fifo.push_back(ch);
				end
			end
			s2a_pkg::CMD_READ: begin
				if (char_fifo.size() > 0) begin
					r.out_char   = char_fifo.pop_front();
					r.char_valid = 1'b1;
				end
			end
			s2a_pkg::CMD_FLUSH: begin
				char_fifo.delete();
			end
			default: begin
			end
		endcase
		r.queue_level = s2a_pkg::LEVEL_W'(char_fifo.size());
		return r;
	endfunction

	// Offers one request, holding off at random first. Inputs change on the
	// falling edge; the handshake is seen on the rising edge. The prediction
	// is made at the edge where the block takes the request.
	task automatic send_request(input logic [s2a_pkg::CMD_W-1:0] cmd,
		input logic [7:0] scan, input logic use_typed, input reply_t typed);
		logic   go;
		reply_t predicted;
		go = 1'b0;
		while (!go) begin
			@(negedge clk);
			go = ($urandom_range(99) >= send_idle_pct);
			req_if.valid <= go;
			if (go) begin
				req_if.command   <= cmd;
				req_if.scan_byte <= scan;
			end
		end
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predicted = apply_request(cmd, scan);
		pending_replies.push_back(use_typed ? typed : predicted);
	endtask

	// Mostly ordinary typing with modifiers, mixed with reads, the odd flush
	// and some raw bytes that reach releases, the prefix and unmapped keys.
	task automatic send_random_request();
		int         pick;
		logic [7:0] scan;
		pick = $urandom_range(99);
		scan = 8'($urandom_range(255));
		if (pick < 45) begin
			send_request(s2a_pkg::CMD_PUSH, {PRESS, 7'($urandom_range('h01, 'h39))},
				1'b0, '0);
		end else if (pick < 52) begin
			send_request(s2a_pkg::CMD_PUSH, {1'($urandom_range(1)),
				($urandom_range(1) ? s2a_pkg::KEY_SHIFT_L : s2a_pkg::KEY_SHIFT_R)},
				1'b0, '0);
		end else if (pick < 55) begin
			send_request(s2a_pkg::CMD_PUSH, {PRESS, s2a_pkg::KEY_CAPS}, 1'b0, '0);
		end else if (pick < 60) begin
			send_request(s2a_pkg::CMD_PUSH, scan, 1'b0, '0);
		end else if (pick < 62) begin
			send_request(s2a_pkg::CMD_PUSH, s2a_pkg::SCAN_PREFIX, 1'b0, '0);
		end else if (pick < 93) begin
			send_request(s2a_pkg::CMD_READ, scan, 1'b0, '0);
		end else if (pick < 96) begin
			send_request(s2a_pkg::CMD_FLUSH, scan, 1'b0, '0);
		end else begin
			send_request(CMD_SPARE, scan, 1'b0, '0);
		end
	endtask

	// Stops offering requests until every owed response has been taken.
	task automatic wait_for_drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// Response side: ready is redrawn on every falling edge.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every response taken is compared with the oldest prediction.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_replies.size() == 0) begin
				$error("response with no request outstanding: char %0h level %0d",
					rsp_if.out_char, rsp_if.queue_level);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_if.out_char !== want.out_char) begin
					$error("out_char expected %0h actual %0h", want.out_char, rsp_if.out_char);
					error_count++;
				end
				if (rsp_if.char_valid !== want.char_valid) begin
					$error("char_valid expected %0b actual %0b", want.char_valid,
						rsp_if.char_valid);
					error_count++;
				end
				if (rsp_if.queue_level !== want.queue_level) begin
					$error("queue_level expected %0d actual %0d", want.queue_level,
						rsp_if.queue_level);
					error_count++;
				end
				if (rsp_if.dropped !== want.dropped) begin
					$error("dropped expected %0b actual %0b", want.dropped, rsp_if.dropped);
					error_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.command   = s2a_pkg::CMD_PUSH;
		req_if.scan_byte = 8'h00;
		shift_on         = 1'b0;
		caps_on          = 1'b0;
		error_count      = 0;
		send_idle_pct    = 38;
		recv_idle_pct    = 75;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// First phase: the request side idles less than the response side.
		foreach (directed_rows[i])
			send_request(directed_rows[i].cmd, directed_rows[i].scan,
				directed_rows[i].typed, directed_rows[i].reply);
		repeat (40)
			send_random_request();

		// Second phase: the roles swap, so responses back up less often.
		wait_for_drain();
		send_idle_pct = 75;
		recv_idle_pct = 38;
		repeat (40)
			send_random_request();

		// Third phase: full rate on both sides. The queue is typed full from
		// wherever its pointers stand, overrun twice, then read dry and one
		// read past empty, so both pointers wrap.
		wait_for_drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (char_fifo.size() < QUEUE_DEPTH)
			send_request(s2a_pkg::CMD_PUSH, {PRESS, 7'($urandom_range('h10, 'h19))},
				1'b0, '0);
		repeat (2)
			send_request(s2a_pkg::CMD_PUSH, {PRESS, 7'($urandom_range('h10, 'h19))},
				1'b0, '0);
		while (char_fifo.size() > 0)
			send_request(s2a_pkg::CMD_READ, 8'($urandom_range(255)), 1'b0, '0);
		send_request(s2a_pkg::CMD_READ, 8'($urandom_range(255)), 1'b0, '0);
		repeat (30)
			send_random_request();

		// Let the last responses come out, then give any stray response a
		// chance to show up before the verdict.
		wait_for_drain();
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/s2a_pkg.sv
hdl/s2a_if.sv
hdl/s2a_decode.sv
hdl/scancode_to_ascii_fifo.sv
hdl/s2a_checker.sv
dv/tb_scancode_to_ascii_fifo.sv
